// ----- hdl/cse_pkg.sv -----
// Shared types, constants and Q16.16 helpers for the cone / segment intersection block.
// Used by every module under hdl; depends on nothing.
package cse_pkg;

    // Step counts of the square-root and divider units
    localparam int SQRT_STEPS = 24;
    localparam int DIV_STEPS  = 32;

    // Discriminant magnitude at or below this counts as a tangent
    localparam logic signed [31:0] DISC_EPSILON = 32'sd1;

    localparam logic signed [51:0] SAT_MAX = 52'sd2147483647;
    localparam logic signed [51:0] SAT_MIN = -52'sd2147483648;

    // Root count codes
    localparam logic [1:0] ROOTS_NONE = 2'd0;
    localparam logic [1:0] ROOTS_ONE  = 2'd1;
    localparam logic [1:0] ROOTS_TWO  = 2'd2;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_APEX_X     = 3'd0,
        CFG_APEX_Y     = 3'd1,
        CFG_APEX_Z     = 3'd2,
        CFG_AXIS_X     = 3'd3,
        CFG_AXIS_Y     = 3'd4,
        CFG_AXIS_Z     = 3'd5,
        CFG_CONE_SLOPE = 3'd6
    } cfg_idx_t;

    typedef struct packed {
        logic signed [31:0] apex_x;
        logic signed [31:0] apex_y;
        logic signed [31:0] apex_z;
        logic signed [17:0] axis_x;
        logic signed [17:0] axis_y;
        logic signed [17:0] axis_z;
        logic [30:0]        cone_slope;
    } cse_cfg_t;

    typedef struct packed {
        logic [30:0]        seg_length;
        logic signed [17:0] dir_z;
        logic signed [17:0] dir_y;
        logic signed [17:0] dir_x;
        logic signed [31:0] origin_z;
        logic signed [31:0] origin_y;
        logic signed [31:0] origin_x;
    } seg_in_t;

    // Quadratic terms that ride along the square-root unit
    typedef struct packed {
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic [1:0]         cnt;
        logic [30:0]        len;
    } root_side_t;

    typedef struct packed {
        logic               seg_hit;
        logic [1:0]         root_count;
        logic signed [31:0] t_second;
        logic signed [31:0] t_first;
    } cse_res_t;

    // Saturate a wide signed value to the 32-bit range
    function automatic logic signed [31:0] sat32(input logic signed [51:0] x);
        logic signed [31:0] r;
        if (x > SAT_MAX) begin
            r = SAT_MAX[31:0];
        end else if (x < SAT_MIN) begin
            r = SAT_MIN[31:0];
        end else begin
            r = x[31:0];
        end
        return r;
    endfunction

    // Q16.16 multiply, round half up, saturate
    function automatic logic signed [31:0] fmul(input logic signed [31:0] x,
                                                input logic signed [31:0] y);
        logic signed [63:0] p;
        logic signed [51:0] r;
        p = x * y;
        p = p + 64'sd32768;
        r = {{4{p[63]}}, p[63:16]};
        return sat32(r);
    endfunction

    // Exact sum of three values, then saturate
    function automatic logic signed [31:0] sum3(input logic signed [31:0] x,
                                                input logic signed [31:0] y,
                                                input logic signed [31:0] z);
        logic signed [51:0] lx;
        logic signed [51:0] ly;
        logic signed [51:0] lz;
        lx = x;
        ly = y;
        lz = z;
        return sat32(lx + ly + lz);
    endfunction

endpackage

// ----- hdl/cone_segment_intersection.sv -----
// Top level of the cone / segment intersection pipeline: config registers, output skid.
// Instantiates cse_quad, cse_sqrt and cse_div; depends on cse_pkg.
//
//  channel   direction  handshake          payload
//  s_*       in         tvalid / tready    segment request (origin, dir, length)
//  m_*       out        tvalid / tready    roots, root count, hit flag
//  cfg_*     in         cfg_we             cone apex, axis, slope
//
// One request per cycle while the skid register is empty; from acceptance to m_tvalid a request passes
// through 8 quadratic stages, 24 square-root stages, 34 divider stages and the output register.
// Reset (aresetn low, synchronous) clears valid bits and loads register defaults.
// The pipeline advances while the skid register is empty; a stalled result waits
// in the output register, the next one in the skid register, then intake stops.
module cone_segment_intersection
    import cse_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, seg_length, zero pad
    input  logic [183:0] s_tdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    // t_first, t_second, root_count, seg_hit, zero pad
    output logic [71:0]  m_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_addr,
    input  logic [31:0]  cfg_wdata
);

    cse_cfg_t   cfg_reg;
    seg_in_t    seg_in;
    logic       en;

    logic       q_valid;
    logic [47:0] q_rad;
    root_side_t q_side;
    logic       r_valid;
    logic [23:0] r_root;
    root_side_t r_side;
    logic       d_valid;
    cse_res_t   d_res;

    logic       out_valid_reg;
    cse_res_t   out_res_reg;
    logic       skid_valid_reg;
    cse_res_t   skid_res_reg;

    // Write configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.apex_x     <= '0;
            cfg_reg.apex_y     <= '0;
            cfg_reg.apex_z     <= '0;
            cfg_reg.axis_x     <= '0;
            cfg_reg.axis_y     <= '0;
            cfg_reg.axis_z     <= 18'sd65536;
            cfg_reg.cone_slope <= 31'd65536;
        end else if (cfg_we) begin
            unique case (cfg_idx_t'(cfg_addr))
                CFG_APEX_X:     cfg_reg.apex_x     <= cfg_wdata;
                CFG_APEX_Y:     cfg_reg.apex_y     <= cfg_wdata;
                CFG_APEX_Z:     cfg_reg.apex_z     <= cfg_wdata;
                CFG_AXIS_X:     cfg_reg.axis_x     <= cfg_wdata[17:0];
                CFG_AXIS_Y:     cfg_reg.axis_y     <= cfg_wdata[17:0];
                CFG_AXIS_Z:     cfg_reg.axis_z     <= cfg_wdata[17:0];
                CFG_CONE_SLOPE: cfg_reg.cone_slope <= cfg_wdata[30:0];
                default: ;
            endcase
        end
    end

    assign seg_in   = s_tdata[180:0];
    assign en       = !skid_valid_reg;
    assign s_tready = en;

    cse_quad u_quad (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .cfg       (cfg_reg),
        .in_valid  (s_tvalid),
        .in_seg    (seg_in),
        .out_valid (q_valid),
        .out_rad   (q_rad),
        .out_side  (q_side)
    );

    cse_sqrt u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (q_valid),
        .in_rad    (q_rad),
        .in_side   (q_side),
        .out_valid (r_valid),
        .out_root  (r_root),
        .out_side  (r_side)
    );

    cse_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (r_valid),
        .in_root   (r_root),
        .in_side   (r_side),
        .out_valid (d_valid),
        .out_res   (d_res)
    );

    // Output register with skid: drain skid first, park the tail result when held
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_tready) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= d_valid;
            end
        end else if (d_valid) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || m_tready) begin
            out_res_reg <= skid_valid_reg ? skid_res_reg : d_res;
        end else if (en) begin
            skid_res_reg <= d_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_res_reg};

    // Skid holds a result only behind a full output register
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register full while output register empty");

    // A hit needs a root
    a_hit_needs_root: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_res_reg.seg_hit) |-> (out_res_reg.root_count != ROOTS_NONE))
        else $error("hit reported without a root");

    // No root means zero roots
    a_none_is_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_res_reg.root_count == ROOTS_NONE) |->
        (out_res_reg.t_first == 32'sd0 && out_res_reg.t_second == 32'sd0 &&
         !out_res_reg.seg_hit))
        else $error("nonzero roots with no intersection");

    // Tangent gives equal roots
    a_tangent_equal: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_res_reg.root_count == ROOTS_ONE) |->
        (out_res_reg.t_first == out_res_reg.t_second))
        else $error("tangent roots differ");

endmodule

// ----- hdl/cse_quad.sv -----
// Front pipeline: offsets, dot products, quadratic terms a, b, c and the discriminant.
// Eight register stages; depends on cse_pkg.
module cse_quad
    import cse_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        en,
    input  cse_cfg_t    cfg,
    input  logic        in_valid,
    input  seg_in_t     in_seg,
    output logic        out_valid,
    output logic [47:0] out_rad,
    output root_side_t  out_side
);

    logic [7:0] vld_reg;

    // Stage 1: q = origin - apex
    logic signed [31:0] q_reg [3];
    logic signed [17:0] v_reg [3];
    logic [30:0]        len1_reg;
    // Stage 2: element products
    logic signed [31:0] pqw_reg [3];
    logic signed [31:0] pvw_reg [3];
    logic signed [31:0] pqv_reg [3];
    logic signed [31:0] pqq_reg [3];
    logic signed [31:0] pvv_reg [3];
    logic signed [31:0] k2_2_reg;
    logic [30:0]        len2_reg;
    // Stage 3: dot products
    logic signed [31:0] qw_reg, vw_reg, qv_reg, qq_reg, vv_reg, k2_3_reg;
    logic [30:0]        len3_reg;
    // Stage 4: squares of projections
    logic signed [31:0] vw2_reg, qw2_reg, h_reg, vv4_reg, qv4_reg, qq4_reg, k2_4_reg;
    logic [30:0]        len4_reg;
    // Stage 5: slope terms
    logic signed [31:0] kv_reg, kh_reg, kq_reg;
    logic signed [31:0] vv5_reg, vw2_5_reg, qv5_reg, h5_reg, qq5_reg, qw2_5_reg;
    logic [30:0]        len5_reg;
    // Stage 6: a, b, c
    logic signed [31:0] a6_reg, b6_reg, c6_reg;
    logic [30:0]        len6_reg;
    // Stage 7: b*b and a*c
    logic signed [31:0] bb_reg, ac_reg, a7_reg, b7_reg;
    logic [30:0]        len7_reg;
    // Stage 8: discriminant and root class
    logic [47:0]        rad_reg;
    root_side_t         side_reg;

    logic signed [31:0] org [3];
    logic signed [31:0] apx [3];
    logic signed [31:0] wx  [3];
    logic signed [31:0] vx  [3];
    logic signed [31:0] kx;
    logic signed [51:0] d_wide;
    logic signed [51:0] bb_w;
    logic signed [51:0] ac_w;
    logic signed [31:0] d_val;
    logic [1:0]         cnt_val;

    always_comb begin
        org[0] = in_seg.origin_x;
        org[1] = in_seg.origin_y;
        org[2] = in_seg.origin_z;
        apx[0] = cfg.apex_x;
        apx[1] = cfg.apex_y;
        apx[2] = cfg.apex_z;
        wx[0]  = {{14{cfg.axis_x[17]}}, cfg.axis_x};
        wx[1]  = {{14{cfg.axis_y[17]}}, cfg.axis_y};
        wx[2]  = {{14{cfg.axis_z[17]}}, cfg.axis_z};
        for (int i = 0; i < 3; i++) begin
            vx[i] = {{14{v_reg[i][17]}}, v_reg[i]};
        end
        kx = {1'b0, cfg.cone_slope};
    end

    // Discriminant and root class for stage 8
    always_comb begin
        bb_w   = bb_reg;
        ac_w   = ac_reg;
        d_wide = bb_w - (ac_w <<< 2);
        d_val  = sat32(d_wide);
        if (a7_reg == 32'sd0) begin
            cnt_val = ROOTS_NONE;
        end else if (d_val >= -DISC_EPSILON && d_val <= DISC_EPSILON) begin
            cnt_val = ROOTS_ONE;
        end else if (d_val > 32'sd0) begin
            cnt_val = ROOTS_TWO;
        end else begin
            cnt_val = ROOTS_NONE;
        end
    end

    // Advance valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[6:0], in_valid};
        end
    end

    // Advance payload
    always_ff @(posedge aclk) begin
        logic signed [51:0] o_w;
        logic signed [51:0] a_w;
        logic signed [51:0] t0_w;
        logic signed [51:0] t1_w;
        logic signed [51:0] t2_w;
        if (en) begin
            // stage 1
            for (int i = 0; i < 3; i++) begin
                o_w = org[i];
                a_w = apx[i];
                q_reg[i] <= sat32(o_w - a_w);
            end
            v_reg[0] <= in_seg.dir_x;
            v_reg[1] <= in_seg.dir_y;
            v_reg[2] <= in_seg.dir_z;
            len1_reg <= in_seg.seg_length;
            // stage 2
            for (int i = 0; i < 3; i++) begin
                pqw_reg[i] <= fmul(q_reg[i], wx[i]);
                pvw_reg[i] <= fmul(vx[i], wx[i]);
                pqv_reg[i] <= fmul(q_reg[i], vx[i]);
                pqq_reg[i] <= fmul(q_reg[i], q_reg[i]);
                pvv_reg[i] <= fmul(vx[i], vx[i]);
            end
            k2_2_reg <= fmul(kx, kx);
            len2_reg <= len1_reg;
            // stage 3
            qw_reg   <= sum3(pqw_reg[0], pqw_reg[1], pqw_reg[2]);
            vw_reg   <= sum3(pvw_reg[0], pvw_reg[1], pvw_reg[2]);
            qv_reg   <= sum3(pqv_reg[0], pqv_reg[1], pqv_reg[2]);
            qq_reg   <= sum3(pqq_reg[0], pqq_reg[1], pqq_reg[2]);
            vv_reg   <= sum3(pvv_reg[0], pvv_reg[1], pvv_reg[2]);
            k2_3_reg <= k2_2_reg;
            len3_reg <= len2_reg;
            // stage 4
            vw2_reg  <= fmul(vw_reg, vw_reg);
            qw2_reg  <= fmul(qw_reg, qw_reg);
            h_reg    <= fmul(qw_reg, vw_reg);
            vv4_reg  <= vv_reg;
            qv4_reg  <= qv_reg;
            qq4_reg  <= qq_reg;
            k2_4_reg <= k2_3_reg;
            len4_reg <= len3_reg;
            // stage 5
            kv_reg    <= fmul(k2_4_reg, vw2_reg);
            kh_reg    <= fmul(k2_4_reg, h_reg);
            kq_reg    <= fmul(k2_4_reg, qw2_reg);
            vv5_reg   <= vv4_reg;
            vw2_5_reg <= vw2_reg;
            qv5_reg   <= qv4_reg;
            h5_reg    <= h_reg;
            qq5_reg   <= qq4_reg;
            qw2_5_reg <= qw2_reg;
            len5_reg  <= len4_reg;
            // stage 6
            t0_w = vv5_reg;
            t1_w = vw2_5_reg;
            t2_w = kv_reg;
            a6_reg <= sat32(t0_w - t1_w - t2_w);
            t0_w = qv5_reg;
            t1_w = h5_reg;
            t2_w = kh_reg;
            b6_reg <= sat32((t0_w <<< 1) - (t1_w <<< 1) - (t2_w <<< 1));
            t0_w = qq5_reg;
            t1_w = qw2_5_reg;
            t2_w = kq_reg;
            c6_reg   <= sat32(t0_w - t1_w - t2_w);
            len6_reg <= len5_reg;
            // stage 7
            bb_reg   <= fmul(b6_reg, b6_reg);
            ac_reg   <= fmul(a6_reg, c6_reg);
            a7_reg   <= a6_reg;
            b7_reg   <= b6_reg;
            len7_reg <= len6_reg;
            // stage 8: radicand is D * 2^16 when two roots, else zero
            rad_reg      <= (cnt_val == ROOTS_TWO) ? {d_val, 16'h0000} : 48'd0;
            side_reg.a   <= a7_reg;
            side_reg.b   <= b7_reg;
            side_reg.cnt <= cnt_val;
            side_reg.len <= len7_reg;
        end
    end

    assign out_valid = vld_reg[7];
    assign out_rad   = rad_reg;
    assign out_side  = side_reg;

endmodule

// ----- hdl/cse_sqrt.sv -----
// Pipelined integer square root, one result bit per stage (restoring form).
// Carries the quadratic terms alongside; depends on cse_pkg.
module cse_sqrt
    import cse_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        en,
    input  logic        in_valid,
    input  logic [47:0] in_rad,
    input  root_side_t  in_side,
    output logic        out_valid,
    output logic [23:0] out_root,
    output root_side_t  out_side
);

    logic [SQRT_STEPS-1:0] vld_reg;
    logic [25:0]           rem_reg  [SQRT_STEPS];
    logic [23:0]           root_reg [SQRT_STEPS];
    logic [47:0]           rad_reg  [SQRT_STEPS];
    root_side_t            side_reg [SQRT_STEPS];

    logic [25:0]           p_rem  [SQRT_STEPS];
    logic [23:0]           p_root [SQRT_STEPS];
    logic [47:0]           p_rad  [SQRT_STEPS];
    root_side_t            p_side [SQRT_STEPS];
    logic [SQRT_STEPS-1:0] p_vld;

    for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_step
        logic [27:0] rem_sh;
        logic [27:0] trial;
        logic [25:0] rem_next;
        logic [23:0] root_next;

        // Select the stage input
        if (j == 0) begin : g_first
            assign p_rem[j]  = '0;
            assign p_root[j] = '0;
            assign p_rad[j]  = in_rad;
            assign p_side[j] = in_side;
            assign p_vld[j]  = in_valid;
        end else begin : g_rest
            assign p_rem[j]  = rem_reg[j-1];
            assign p_root[j] = root_reg[j-1];
            assign p_rad[j]  = rad_reg[j-1];
            assign p_side[j] = side_reg[j-1];
            assign p_vld[j]  = vld_reg[j-1];
        end

        // Bring down two radicand bits, try the next root bit
        always_comb begin
            rem_sh = {p_rem[j], p_rad[j][47:46]};
            trial  = {2'b00, p_root[j], 2'b01};
            if (rem_sh >= trial) begin
                rem_next  = 26'(rem_sh - trial);
                root_next = {p_root[j][22:0], 1'b1};
            end else begin
                rem_next  = rem_sh[25:0];
                root_next = {p_root[j][22:0], 1'b0};
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[j] <= 1'b0;
            end else if (en) begin
                vld_reg[j] <= p_vld[j];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[j]  <= rem_next;
                root_reg[j] <= root_next;
                rad_reg[j]  <= {p_rad[j][45:0], 2'b00};
                side_reg[j] <= p_side[j];
            end
        end
    end

    assign out_valid = vld_reg[SQRT_STEPS-1];
    assign out_root  = root_reg[SQRT_STEPS-1];
    assign out_side  = side_reg[SQRT_STEPS-1];

endmodule

// ----- hdl/cse_div.sv -----
// Two-lane pipelined divider for (-b +/- sqrtD) / 2a, then saturation and segment test.
// One quotient bit per stage; depends on cse_pkg.
module cse_div
    import cse_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        en,
    input  logic        in_valid,
    input  logic [23:0] in_root,
    input  root_side_t  in_side,
    output logic        out_valid,
    output cse_res_t    out_res
);

    typedef struct packed {
        logic [32:0] rem;
        logic [31:0] dq;    // dividend bits shift out, quotient bits shift in
        logic        ovf;
        logic        neg;
    } lane_t;

    typedef struct packed {
        logic [32:0] dmag;
        logic [1:0]  cnt;
        logic [30:0] len;
    } div_side_t;

    logic [DIV_STEPS:0] vld_reg;
    lane_t [1:0]        lane_reg [DIV_STEPS+1];
    div_side_t          side_reg [DIV_STEPS+1];
    cse_res_t           res_reg;
    logic               res_vld_reg;

    lane_t [1:0]        prep_next;
    div_side_t          prep_side;

    // Form numerators, denominator magnitude and the overflow check
    always_comb begin
        logic signed [33:0] bx;
        logic signed [33:0] sx;
        logic signed [33:0] num;
        logic signed [33:0] den;
        logic [33:0]        nmag;
        logic [33:0]        dmag;
        logic [47:0]        dvd;
        bx  = in_side.b;
        sx  = {10'd0, in_root};
        den = {in_side.a[31], in_side.a, 1'b0};
        dmag = den[33] ? 34'(-den) : den;
        for (int i = 0; i < 2; i++) begin
            num  = (i == 0) ? (-bx + sx) : (-bx - sx);
            nmag = num[33] ? 34'(-num) : num;
            dvd  = {nmag[31:0], 16'h0000};
            prep_next[i].rem = {17'd0, dvd[47:32]};
            prep_next[i].dq  = dvd[31:0];
            prep_next[i].ovf = ({17'd0, dvd[47:32]} >= dmag[32:0]);
            prep_next[i].neg = num[33] ^ in_side.a[31];
        end
        prep_side.dmag = dmag[32:0];
        prep_side.cnt  = in_side.cnt;
        prep_side.len  = in_side.len;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg[0] <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            lane_reg[0] <= prep_next;
            side_reg[0] <= prep_side;
        end
    end

    // Restoring division steps
    for (genvar j = 1; j <= DIV_STEPS; j++) begin : g_step
        lane_t [1:0] step_next;

        always_comb begin
            logic [33:0] rsh;
            for (int i = 0; i < 2; i++) begin
                rsh = {lane_reg[j-1][i].rem, lane_reg[j-1][i].dq[31]};
                step_next[i].ovf = lane_reg[j-1][i].ovf;
                step_next[i].neg = lane_reg[j-1][i].neg;
                if (rsh >= {1'b0, side_reg[j-1].dmag}) begin
                    step_next[i].rem = 33'(rsh - {1'b0, side_reg[j-1].dmag});
                    step_next[i].dq  = {lane_reg[j-1][i].dq[30:0], 1'b1};
                end else begin
                    step_next[i].rem = rsh[32:0];
                    step_next[i].dq  = {lane_reg[j-1][i].dq[30:0], 1'b0};
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[j] <= 1'b0;
            end else if (en) begin
                vld_reg[j] <= vld_reg[j-1];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                lane_reg[j] <= step_next;
                side_reg[j] <= side_reg[j-1];
            end
        end
    end

    // Saturate quotients, blank when no root, test the segment range
    cse_res_t res_next;

    always_comb begin
        logic signed [31:0] t [2];
        logic [31:0]        q;
        logic               big;
        for (int i = 0; i < 2; i++) begin
            q = lane_reg[DIV_STEPS][i].dq;
            if (lane_reg[DIV_STEPS][i].neg) begin
                big  = lane_reg[DIV_STEPS][i].ovf || (q[31] && (|q[30:0]));
                t[i] = big ? SAT_MIN[31:0] : 32'(-q);
            end else begin
                big  = lane_reg[DIV_STEPS][i].ovf || q[31];
                t[i] = big ? SAT_MAX[31:0] : q;
            end
        end
        if (side_reg[DIV_STEPS].cnt == ROOTS_NONE) begin
            res_next.t_first  = '0;
            res_next.t_second = '0;
            res_next.seg_hit  = 1'b0;
        end else begin
            res_next.t_first  = t[0];
            res_next.t_second = t[1];
            res_next.seg_hit  =
                (t[0] >= 32'sd0 && t[0] <= $signed({1'b0, side_reg[DIV_STEPS].len})) ||
                (t[1] >= 32'sd0 && t[1] <= $signed({1'b0, side_reg[DIV_STEPS].len}));
        end
        res_next.root_count = side_reg[DIV_STEPS].cnt;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_vld_reg <= 1'b0;
        end else if (en) begin
            res_vld_reg <= vld_reg[DIV_STEPS];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            res_reg <= res_next;
        end
    end

    assign out_valid = res_vld_reg;
    assign out_res   = res_reg;

endmodule

// ----- verif/cone_segment_intersection_test.sv -----
// Self-checking bench for cone_segment_intersection: random and directed segment requests.
// Results are predicted by a Q16.16 root solver below; depends on cse_pkg and the block RTL.
`timescale 1ns / 1ps

module cone_segment_intersection_test;
    import cse_pkg::*;

    localparam int LATENCY   = 67;
    localparam int IDLE_WAIT = LATENCY + 20;
    localparam int DOG_LIMIT = 6000;
    localparam int PER_PHASE = 200;

    // Q16.16 cone solver and the queue of roots still owed by the block
    class cone_root_board;
        longint apex[3];
        longint axis[3];
        longint slope;
        cse_res_t pending_roots[$];
        int errors;

        function new();
            apex = '{0, 0, 0};
            axis = '{0, 0, 65536};
            slope = 65536;
            errors = 0;
        endfunction

        function void set_reg(cfg_idx_t idx, logic [31:0] val);
            case (idx)
                CFG_APEX_X:     apex[0] = longint'($signed(val));
                CFG_APEX_Y:     apex[1] = longint'($signed(val));
                CFG_APEX_Z:     apex[2] = longint'($signed(val));
                CFG_AXIS_X:     axis[0] = longint'($signed(val[17:0]));
                CFG_AXIS_Y:     axis[1] = longint'($signed(val[17:0]));
                CFG_AXIS_Z:     axis[2] = longint'($signed(val[17:0]));
                CFG_CONE_SLOPE: slope = longint'(val[30:0]);
                default: ;
            endcase
        endfunction

        function longint clip(longint x);
            if (x > 64'sd2147483647) return 64'sd2147483647;
            if (x < -64'sd2147483648) return -64'sd2147483648;
            return x;
        endfunction

        // round half up, i.e. floor of (p + half)
        function longint qmul(longint x, longint y);
            return clip((x * y + 32768) >>> 16);
        endfunction

        function longint dot(longint u[3], longint v[3]);
            return clip(qmul(u[0], v[0]) + qmul(u[1], v[1]) + qmul(u[2], v[2]));
        endfunction

        function longint int_sqrt(longint n);
            longint res;
            longint b;
            res = 0;
            b = 64'sd1 <<< 62;
            while (b > n) b = b >>> 2;
            while (b != 0) begin
                if (n >= res + b) begin
                    n = n - (res + b);
                    res = (res >>> 1) + b;
                end else begin
                    res = res >>> 1;
                end
                b = b >>> 2;
            end
            return res;
        endfunction

        function longint qdiv(longint num, longint den);
            return clip((num * 65536) / den);
        endfunction

        function bit on_segment(longint t, longint len);
            return t >= 0 && t <= len;
        endfunction

        // note an accepted segment request and queue its roots
        function void note_segment(seg_in_t s);
            longint q[3], v[3];
            longint k2, qw, vw, qv, qq, vv, vw2, qw2, h, a, b, c, d, ad, sr, len;
            cse_res_t r;
            q[0] = clip(longint'(s.origin_x) - apex[0]);
            q[1] = clip(longint'(s.origin_y) - apex[1]);
            q[2] = clip(longint'(s.origin_z) - apex[2]);
            v[0] = longint'(s.dir_x);
            v[1] = longint'(s.dir_y);
            v[2] = longint'(s.dir_z);
            len = longint'(s.seg_length);
            k2 = qmul(slope, slope);
            qw = dot(q, axis);
            vw = dot(v, axis);
            qv = dot(q, v);
            qq = dot(q, q);
            vv = dot(v, v);
            vw2 = qmul(vw, vw);
            qw2 = qmul(qw, qw);
            h = qmul(qw, vw);
            a = clip(vv - vw2 - qmul(k2, vw2));
            b = clip(2 * qv - 2 * h - 2 * qmul(k2, h));
            c = clip(qq - qw2 - qmul(k2, qw2));
            d = clip(qmul(b, b) - 4 * qmul(a, c));
            r = '0;
            r.root_count = ROOTS_NONE;
            if (a != 0) begin
                ad = d < 0 ? -d : d;
                if (ad <= longint'(DISC_EPSILON)) begin
                    r.t_first = 32'(qdiv(-b, 2 * a));
                    r.t_second = r.t_first;
                    r.root_count = ROOTS_ONE;
                end else if (d > 0) begin
                    sr = int_sqrt(d * 65536);
                    r.t_first = 32'(qdiv(-b + sr, 2 * a));
                    r.t_second = 32'(qdiv(-b - sr, 2 * a));
                    r.root_count = ROOTS_TWO;
                end
            end
            if (r.root_count != ROOTS_NONE)
                r.seg_hit = on_segment(longint'(r.t_first), len)
                         || on_segment(longint'(r.t_second), len);
            pending_roots.push_back(r);
        endfunction

        // compare one delivered result against the oldest prediction
        function void check_roots(cse_res_t got);
            cse_res_t want;
            if (pending_roots.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
                return;
            end
            want = pending_roots.pop_front();
            if (got.t_first !== want.t_first) begin
                $display("%0t: t_first exp %h got %h", $time, want.t_first, got.t_first);
                errors++;
            end
            if (got.t_second !== want.t_second) begin
                $display("%0t: t_second exp %h got %h", $time, want.t_second, got.t_second);
                errors++;
            end
            if (got.root_count !== want.root_count) begin
                $display("%0t: root_count exp %0d got %0d", $time, want.root_count,
                         got.root_count);
                errors++;
            end
            if (got.seg_hit !== want.seg_hit) begin
                $display("%0t: seg_hit exp %0d got %0d", $time, want.seg_hit, got.seg_hit);
                errors++;
            end
        endfunction
    endclass

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic [183:0] s_tdata = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [71:0]  m_tdata;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic         cfg_we = 1'b0;
    logic [2:0]   cfg_addr = '0;
    logic [31:0]  cfg_wdata = '0;

    cone_root_board board = new();
    bit no_idle = 1'b0;
    bit hold_req = 1'b0;
    int quiet_cycles = 0;

    cone_segment_intersection i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // observe both channels, feed the board, and watch for a hang
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                board.note_segment(seg_in_t'(s_tdata[180:0]));
            if (m_tvalid && m_tready)
                board.check_roots(cse_res_t'(m_tdata[66:0]));
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= DOG_LIMIT) begin
                $display("cone_segment_intersection: mismatch");
                $finish;
            end
        end
    end

    // result side: random stalls, one long hold-off on request
    initial begin : receiver
        int hold_left;
        int r;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (hold_req && hold_left == 0) begin
                hold_left = 400;
                hold_req = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (no_idle || !aresetn) begin
                m_tready <= aresetn;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 2)
                    hold_left = $urandom_range(15, 60);
                else if (r < 20)
                    hold_left = $urandom_range(0, 3);
                m_tready <= (hold_left == 0);
            end
        end
    end

    task automatic write_reg(cfg_idx_t idx, logic [31:0] val);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        board.set_reg(idx, val);
        @(posedge aclk);
    endtask

    task automatic load_cone(logic [31:0] ax, logic [31:0] ay, logic [31:0] az,
                             logic [31:0] wx, logic [31:0] wy, logic [31:0] wz,
                             logic [31:0] k);
        write_reg(CFG_APEX_X, ax);
        write_reg(CFG_APEX_Y, ay);
        write_reg(CFG_APEX_Z, az);
        write_reg(CFG_AXIS_X, wx & 32'h3FFFF);
        write_reg(CFG_AXIS_Y, wy & 32'h3FFFF);
        write_reg(CFG_AXIS_Z, wz & 32'h3FFFF);
        write_reg(CFG_CONE_SLOPE, k & 32'h7FFFFFFF);
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    // offer one request after a random gap, hold it until taken
    task automatic send_segment(seg_in_t s);
        int gap;
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 65)
            gap = 0;
        else if (r < 95)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(8, 40);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {3'b000, s};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (board.pending_roots.size() != 0) @(posedge aclk);
        repeat (IDLE_WAIT) @(posedge aclk);
    endtask

    function automatic logic [17:0] unit_comp();
        return 18'($urandom_range(0, 131072) - 65536);
    endfunction

    function automatic seg_in_t make_seg(longint ox, longint oy, longint oz,
                                         longint dx, longint dy, longint dz, longint len);
        seg_in_t s;
        s.origin_x = 32'(ox);
        s.origin_y = 32'(oy);
        s.origin_z = 32'(oz);
        s.dir_x = 18'(dx);
        s.dir_y = 18'(dy);
        s.dir_z = 18'(dz);
        s.seg_length = 31'(len);
        return s;
    endfunction

    // mostly geometry near the apex so roots land on and off the segment
    function automatic seg_in_t random_seg();
        seg_in_t s;
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            s = make_seg(longint'($urandom_range(0, 1310720)) - 655360,
                         longint'($urandom_range(0, 1310720)) - 655360,
                         longint'($urandom_range(0, 1310720)) - 655360,
                         0, 0, 0, $urandom_range(0, 1966080));
            s.dir_x = unit_comp();
            s.dir_y = unit_comp();
            s.dir_z = unit_comp();
        end else begin
            s.origin_x = $urandom();
            s.origin_y = $urandom();
            s.origin_z = $urandom();
            s.dir_x = unit_comp();
            s.dir_y = unit_comp();
            s.dir_z = unit_comp();
            s.seg_length = 31'($urandom());
        end
        return s;
    endfunction

    initial begin : stimulus
        longint one;
        longint qmax;
        longint qmin;
        one = 65536;
        qmax = 64'sd2147483647;
        qmin = -64'sd2147483648;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed requests against the reset cone
        send_segment(make_seg(0, 0, 5 * one, one, 0, 0, 10 * one));     // two roots
        send_segment(make_seg(0, 0, 0, one, 0, 0, one));                // tangent at apex
        send_segment(make_seg(5 * one, 0, 0, 0, one, 0, 10 * one));     // negative disc
        send_segment(make_seg(3 * one, 0, 0, 0, 0, 0, 10 * one));       // zero direction
        send_segment(make_seg(0, 0, 5 * one, one, 0, 0, 0));            // zero length
        send_segment(make_seg(-7 * one, 0, 2 * one, one, 0, 0, qmax));  // roots ahead
        send_segment(make_seg(qmax, qmax, qmax, one, one, one, qmax));
        send_segment(make_seg(qmin, qmin, qmin, -one, -one, -one, 0));
        send_segment(make_seg(qmax, qmin, 0, -one, one, 0, qmax));
        send_segment(make_seg(qmin, qmax, qmax, one, -one, one, one));
        send_segment(make_seg(0, 0, 3 * one, 0, 0, one, 8 * one));      // along the axis
        send_segment(make_seg(one, 0, 0, 0, 0, one, 4 * one));          // negative a, roots at -1 and +1
        send_segment(make_seg(2 * one, 0, 0, 2 * one, one, 0, 5 * one));
        send_segment(make_seg(0, 0, -4 * one, one, 0, one, qmax));
        drain();

        for (int phase = 0; phase < 7; phase++) begin
            case (phase)
                0: load_cone(32'(qmax), 32'(qmax), 32'(qmax), 65536, 65536, 65536,
                             32'(qmax));
                1: load_cone(32'(qmin), 32'(qmin), 32'(qmin), -65536, -65536, -65536, 0);
                2: load_cone(0, 0, 0, 65536, 0, 0, 32768);
                3: load_cone($urandom_range(0, 131072) - 65536,
                             $urandom_range(0, 131072) - 65536, 0, 0, 46341, 46341,
                             $urandom_range(16384, 196608));
                4: load_cone($urandom(), $urandom(), $urandom(), unit_comp(), unit_comp(),
                             unit_comp(), $urandom());
                5: load_cone(0, 0, one, 0, 0, -65536, 131072);
                default: load_cone(0, 0, 0, 0, 0, 65536, 65536);
            endcase
            no_idle = (phase == 5);
            for (int n = 0; n < PER_PHASE; n++) begin
                // let the result side stall long while requests keep coming
                if (phase == 3 && n == 20) begin
                    hold_req = 1'b1;
                    no_idle = 1'b1;
                end
                if (phase == 3 && n == 120)
                    no_idle = 1'b0;
                send_segment(random_seg());
            end
            drain();
        end
        no_idle = 1'b0;

        if (board.errors == 0 && board.pending_roots.size() == 0) begin
            $display("cone_segment_intersection: match");
        end else begin
            $display("cone_segment_intersection: mismatch");
        end
        $finish;
    end

endmodule
